// ----- hw/rtl/command_slot_allocator_assert.svh -----
// assertion macros for the command slot allocator rtl
// depends on nothing; included by files that carry concurrent checks
`ifndef COMMAND_SLOT_ALLOCATOR_ASSERT_SVH
`define COMMAND_SLOT_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define CSA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CSA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/csa_pkg.sv -----
// shared constants, command codes and control structs of the slot allocator
// depends on nothing
package csa_pkg;

    localparam int MAX_SLOTS_DEF = 128;
    localparam int CHUNK = 32;
    localparam int CHUNK_W = 5;
    localparam logic [7:0] SLOTS_RESET = 8'd128;

    localparam logic [2:0] CMD_ACQUIRE      = 3'd0;
    localparam logic [2:0] CMD_ACQUIRE_CTRL = 3'd1;
    localparam logic [2:0] CMD_RELEASE      = 3'd2;
    localparam logic [2:0] CMD_RELEASE_CTRL = 3'd3;
    localparam logic [2:0] CMD_CLEAR        = 3'd4;

    localparam logic REG_SLOTS_IN_USE = 1'b0;

    typedef struct packed {
        logic load;
        logic step;
        logic fin_acq;
        logic exec;
    } csa_cmd_t;

    typedef struct packed {
        logic hit;
        logic last_chunk;
    } csa_stat_t;

endpackage

// ----- hw/rtl/csa_ctrl.sv -----
// controller state machine of the slot allocator: sequences load, scan and execute
// depends on csa_pkg
module csa_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                cmd_is_acq,
    input  csa_pkg::csa_stat_t  stat,
    output csa_pkg::csa_cmd_t   ctl,
    output logic                busy
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_EXEC = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        ctl = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ctl.load = 1'b1;
                    state_next = cmd_is_acq ? ST_SCAN : ST_EXEC;
                end
            end
            ST_SCAN:
            begin
                if (stat.hit || stat.last_chunk)
                begin
                    ctl.fin_acq = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    ctl.step = 1'b1;
                end
            end
            ST_EXEC:
            begin
                ctl.exec = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// ----- hw/rtl/csa_datapath.sv -----
// datapath of the slot allocator: busy map, flags, chunked first-free search, results
// depends on csa_pkg and command_slot_allocator_assert.svh
`include "command_slot_allocator_assert.svh"

module csa_datapath #(
    parameter int MAX_SLOTS = csa_pkg::MAX_SLOTS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  csa_pkg::csa_cmd_t   ctl,
    output csa_pkg::csa_stat_t  stat,
    input  logic [2:0]          cmd,
    input  logic [6:0]          slot,
    input  logic [7:0]          slots_in_use,
    output logic                done,
    output logic                ok,
    output logic [6:0]          granted_slot,
    output logic                control_busy,
    output logic                configured
);

    localparam int NCHUNK = (MAX_SLOTS + csa_pkg::CHUNK - 1) / csa_pkg::CHUNK;
    localparam int CNT_W  = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int IDX_W  = CNT_W + csa_pkg::CHUNK_W;
    localparam int PAD_W  = NCHUNK * csa_pkg::CHUNK;
    localparam int CMP_W  = (IDX_W > 8) ? IDX_W + 1 : 9;

    logic [2:0]                   cmd_reg;
    logic [6:0]                   slot_reg;
    logic [CNT_W-1:0]             chunk_reg;
    logic [CNT_W-1:0]             chunk_next;
    logic [MAX_SLOTS-1:0]         map_reg;
    logic [MAX_SLOTS-1:0]         map_next;
    logic                         ctrl_reg;
    logic                         ctrl_next;
    logic                         conf_reg;
    logic                         conf_next;
    logic                         ok_reg;
    logic                         ok_next;
    logic [6:0]                   granted_reg;
    logic [6:0]                   granted_next;
    logic                         done_reg;
    logic                         done_next;

    logic [PAD_W-1:0]             free_vec;
    logic [csa_pkg::CHUNK-1:0]    chunk_bits;
    logic [csa_pkg::CHUNK_W-1:0]  pos;
    logic [IDX_W-1:0]             idx;
    logic                         below;
    logic                         grant_ok;

    // padding past the map reads as busy
    always_comb
    begin
        free_vec = '0;
        free_vec[MAX_SLOTS-1:0] = ~map_reg;
    end

    assign chunk_bits = free_vec[{chunk_reg, {csa_pkg::CHUNK_W{1'b0}}} +: csa_pkg::CHUNK];

    // lowest set bit of the chunk
    always_comb
    begin
        pos = '0;
        for (int i = csa_pkg::CHUNK - 1; i >= 0; i--)
        begin
            if (chunk_bits[i])
            begin
                pos = csa_pkg::CHUNK_W'(i);
            end
        end
    end

    assign idx             = {chunk_reg, pos};
    assign stat.hit        = |chunk_bits;
    assign stat.last_chunk = (chunk_reg == CNT_W'(NCHUNK - 1));
    assign below           = (CMP_W'(idx) < CMP_W'(slots_in_use));
    assign grant_ok        = stat.hit && below;

    always_comb
    begin
        map_next     = map_reg;
        ctrl_next    = ctrl_reg;
        conf_next    = conf_reg;
        ok_next      = ok_reg;
        granted_next = granted_reg;
        done_next    = 1'b0;
        chunk_next   = chunk_reg;

        if (ctl.load)
        begin
            chunk_next = '0;
        end
        if (ctl.step)
        begin
            chunk_next = chunk_reg + CNT_W'(1);
        end

        if (ctl.fin_acq)
        begin
            done_next    = 1'b1;
            ok_next      = grant_ok;
            granted_next = grant_ok ? 7'(idx) : 7'd0;
            if (grant_ok)
            begin
                for (int i = 0; i < MAX_SLOTS; i++)
                begin
                    if (IDX_W'(i) == idx)
                    begin
                        map_next[i] = 1'b1;
                    end
                end
            end
        end

        if (ctl.exec)
        begin
            done_next    = 1'b1;
            granted_next = 7'd0;
            unique case (cmd_reg)
                csa_pkg::CMD_ACQUIRE_CTRL:
                begin
                    map_next[0] = 1'b1;
                    ok_next     = !ctrl_reg;
                    ctrl_next   = 1'b1;
                end
                csa_pkg::CMD_RELEASE:
                begin
                    for (int i = 0; i < MAX_SLOTS; i++)
                    begin
                        if (int'(slot_reg) == i)
                        begin
                            map_next[i] = 1'b0;
                        end
                    end
                    ok_next = 1'b1;
                end
                csa_pkg::CMD_RELEASE_CTRL:
                begin
                    ctrl_next = 1'b0;
                    conf_next = 1'b1;
                    ok_next   = 1'b1;
                end
                csa_pkg::CMD_CLEAR:
                begin
                    map_next = '0;
                    ok_next  = 1'b1;
                end
                default:
                begin
                    ok_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg  <= cmd;
            slot_reg <= slot;
        end
        chunk_reg   <= chunk_next;
        granted_reg <= granted_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_reg  <= '0;
            ctrl_reg <= 1'b0;
            conf_reg <= 1'b0;
            ok_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            map_reg  <= map_next;
            ctrl_reg <= ctrl_next;
            conf_reg <= conf_next;
            ok_reg   <= ok_next;
            done_reg <= done_next;
        end
    end

    assign done         = done_reg;
    assign ok           = ok_reg;
    assign granted_slot = granted_reg;
    assign control_busy = ctrl_reg;
    assign configured   = conf_reg;

    `CSA_ASSERT_NEXT(a_done_single, clk, rst_n, done_reg, !done_reg, "result strobe held twice")
    `CSA_ASSERT_NEXT(a_miss_fails, clk, rst_n, ctl.fin_acq && !stat.hit, !ok_reg, "acquire without free slot granted")
    `CSA_ASSERT_NOW(a_ctrl_grant, clk, rst_n, done_reg && ok_reg && cmd_reg == csa_pkg::CMD_ACQUIRE_CTRL, ctrl_reg, "control grant without flag")
    `CSA_ASSERT_NOW(a_ctrl_release, clk, rst_n, done_reg && cmd_reg == csa_pkg::CMD_RELEASE_CTRL, conf_reg && !ctrl_reg, "control release flags wrong")

endmodule

// ----- hw/rtl/command_slot_allocator.sv -----
// command slot allocator: an item is taken when start is high and busy low. an
// acquire scans the busy map 32 slots a cycle for the lowest free slot and stops at
// the first chunk that holds one (at most ceil(MAX_SLOTS / 32) chunks); done is then
// registered from that chunk. every other command passes through the execute state
// before done. busy falls in the strobe cycle, so a new item may be taken there.
// done is high for exactly one cycle and the receiver cannot stall it.
// slots_in_use sits at apb byte address 0, reset 128.
// depends on csa_pkg, csa_ctrl, csa_datapath
module command_slot_allocator #(
    parameter int MAX_SLOTS = csa_pkg::MAX_SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  cmd,
    input  logic [6:0]  slot,
    output logic        done,
    output logic        ok,
    output logic [6:0]  granted_slot,
    output logic        control_busy,
    output logic        configured,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    csa_pkg::csa_cmd_t  ctl;
    csa_pkg::csa_stat_t stat;
    logic [7:0]         slots_reg;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == csa_pkg::REG_SLOTS_IN_USE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_reg <= csa_pkg::SLOTS_RESET;
        end
        else if (wr_en)
        begin
            slots_reg <= pwdata[7:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == csa_pkg::REG_SLOTS_IN_USE)
        begin
            prdata = {24'd0, slots_reg};
        end
    end

    csa_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .cmd_is_acq (cmd == csa_pkg::CMD_ACQUIRE),
        .stat       (stat),
        .ctl        (ctl),
        .busy       (busy)
    );

    csa_datapath #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .stat         (stat),
        .cmd          (cmd),
        .slot         (slot),
        .slots_in_use (slots_reg),
        .done         (done),
        .ok           (ok),
        .granted_slot (granted_slot),
        .control_busy (control_busy),
        .configured   (configured)
    );

endmodule

// ----- test/command_slot_allocator_tb.sv -----
// self-checking testbench for command_slot_allocator: directed, limit, full-map and
// random traffic tests against an in-bench model of the slot map and flags
// depends on csa_pkg and the command_slot_allocator rtl
`timescale 1ns / 1ps

module command_slot_allocator_tb;

    localparam int SLOT_COUNT = csa_pkg::MAX_SLOTS_DEF;
    localparam logic [2:0] CMD_SPARE_LO = 3'd5;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;
    localparam logic [2:0] ADDR_SLOTS_IN_USE = {csa_pkg::REG_SLOTS_IN_USE, 2'b00};
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_ITEMS = 52;

    typedef struct packed {
        logic       ok;
        logic [6:0] granted;
        logic       ctrl;
        logic       cfg;
    } answer_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  cmd;
    logic [6:0]  slot;
    logic        done;
    logic        ok;
    logic [6:0]  granted_slot;
    logic        control_busy;
    logic        configured;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // model of the allocator state
    logic [SLOT_COUNT-1:0] held_map;
    logic                  ctrl_held;
    logic                  cfg_done;
    logic [7:0]            slot_limit;

    answer_t answer_q[$];
    answer_t seen_answer;
    int      errors = 0;
    int      items_sent = 0;
    int      grants = 0;
    int      refusals = 0;
    int      stall_cycles = 0;
    bit      quiet;

    command_slot_allocator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .slot         (slot),
        .done         (done),
        .ok           (ok),
        .granted_slot (granted_slot),
        .control_busy (control_busy),
        .configured   (configured),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    task automatic predict_answer(input logic [2:0] c, input logic [6:0] s,
                                  output answer_t a);
        int idx;
        a = '0;
        unique case (c)
            csa_pkg::CMD_ACQUIRE:
            begin
                idx = SLOT_COUNT;
                for (int i = SLOT_COUNT - 1; i >= 0; i--)
                begin
                    if (!held_map[i])
                        idx = i;
                end
                if (idx < SLOT_COUNT && idx < int'(slot_limit))
                begin
                    held_map[idx] = 1'b1;
                    a.ok = 1'b1;
                    a.granted = idx[6:0];
                    grants++;
                end
                else
                    refusals++;
            end
            csa_pkg::CMD_ACQUIRE_CTRL:
            begin
                held_map[0] = 1'b1;
                if (!ctrl_held)
                begin
                    ctrl_held = 1'b1;
                    a.ok = 1'b1;
                    grants++;
                end
                else
                    refusals++;
            end
            csa_pkg::CMD_RELEASE:
            begin
                held_map[s] = 1'b0;
                a.ok = 1'b1;
            end
            csa_pkg::CMD_RELEASE_CTRL:
            begin
                ctrl_held = 1'b0;
                cfg_done = 1'b1;
                a.ok = 1'b1;
            end
            csa_pkg::CMD_CLEAR:
            begin
                held_map = '0;
                a.ok = 1'b1;
            end
            default:
            begin
            end
        endcase
        a.ctrl = ctrl_held;
        a.cfg = cfg_done;
    endtask

    task automatic send_item(input logic [2:0] c, input logic [6:0] s);
        int gap;
        answer_t a;
        gap = quiet ? 0 : $urandom_range(0, 16);
        repeat (gap)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start <= 1'b1;
        cmd <= c;
        slot <= s;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_answer(c, s, a);
        answer_q.push_back(a);
        items_sent++;
    endtask

    // stop sending and let every pending result arrive
    task automatic settle();
        @(negedge clk);
        start <= 1'b0;
        while (answer_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    task automatic set_slot_limit(input logic [7:0] v);
        settle();
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_SLOTS_IN_USE;
        pwdata <= {24'($urandom), v};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        slot_limit = v;
        @(negedge clk);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata[7:0] !== v)
        begin
            errors++;
            $display("%0t: slots_in_use readback expected %0d actual %0d",
                     $time, v, prdata[7:0]);
        end
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [6:0] pick_held_slot();
        int base;
        int idx;
        base = $urandom_range(0, SLOT_COUNT - 1);
        for (int k = 0; k < SLOT_COUNT; k++)
        begin
            idx = (base + k) % SLOT_COUNT;
            if (held_map[idx])
                return idx[6:0];
        end
        return base[6:0];
    endfunction

    task automatic check_field(input string name, input logic [6:0] exp_v,
                               input logic [6:0] act_v);
        if (exp_v !== act_v)
        begin
            errors++;
            $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (answer_q.size() == 0)
            begin
                errors++;
                $display("%0t: result strobe with no item pending, expected none actual ok=%0d",
                         $time, ok);
            end
            else
            begin
                seen_answer = answer_q.pop_front();
                check_field("ok", 7'(seen_answer.ok), 7'(ok));
                check_field("granted_slot", seen_answer.granted, granted_slot);
                check_field("control_busy", 7'(seen_answer.ctrl), 7'(control_busy));
                check_field("configured", 7'(seen_answer.cfg), 7'(configured));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
        $display("Verification failed");
        $finish;
    end

    task automatic test_directed();
        quiet = 1'b0;
        send_item(csa_pkg::CMD_ACQUIRE, 7'h00);
        send_item(csa_pkg::CMD_ACQUIRE, 7'h7f);
        send_item(csa_pkg::CMD_ACQUIRE_CTRL, 7'h00);
        send_item(csa_pkg::CMD_ACQUIRE_CTRL, 7'h2a);
        send_item(csa_pkg::CMD_RELEASE, 7'h00);
        send_item(csa_pkg::CMD_ACQUIRE_CTRL, 7'h00);
        send_item(csa_pkg::CMD_RELEASE_CTRL, 7'h7f);
        send_item(csa_pkg::CMD_RELEASE_CTRL, 7'h00);
        send_item(csa_pkg::CMD_ACQUIRE, 7'h55);
        send_item(csa_pkg::CMD_RELEASE, 7'h01);
        send_item(csa_pkg::CMD_RELEASE, 7'h7f);
        send_item(csa_pkg::CMD_RELEASE, 7'h00);
        send_item(csa_pkg::CMD_ACQUIRE, 7'h00);
        send_item(csa_pkg::CMD_CLEAR, 7'h7f);
        send_item(csa_pkg::CMD_ACQUIRE, 7'h2a);
        send_item(csa_pkg::CMD_ACQUIRE_CTRL, 7'h00);
        for (int c = CMD_SPARE_LO; c <= CMD_SPARE_HI; c++)
            send_item(3'(c), 7'h7f);
        send_item(csa_pkg::CMD_RELEASE, 7'h00);
        send_item(csa_pkg::CMD_ACQUIRE, 7'h00);
        settle();
    endtask

    task automatic test_slot_limits();
        set_slot_limit(8'd1);
        send_item(csa_pkg::CMD_CLEAR, 7'h00);
        send_item(csa_pkg::CMD_ACQUIRE, 7'h00);
        send_item(csa_pkg::CMD_ACQUIRE, 7'h00);
        send_item(csa_pkg::CMD_RELEASE, 7'h00);
        send_item(csa_pkg::CMD_ACQUIRE, 7'h00);
        set_slot_limit(8'd0);
        send_item(csa_pkg::CMD_ACQUIRE, 7'h00);
        send_item(csa_pkg::CMD_CLEAR, 7'h00);
        send_item(csa_pkg::CMD_ACQUIRE, 7'h00);
        send_item(csa_pkg::CMD_ACQUIRE_CTRL, 7'h00);
        set_slot_limit(8'd2);
        send_item(csa_pkg::CMD_ACQUIRE, 7'h00);
        send_item(csa_pkg::CMD_ACQUIRE, 7'h00);
        send_item(csa_pkg::CMD_ACQUIRE, 7'h00);
        settle();
    endtask

    task automatic test_map_full();
        set_slot_limit(8'd128);
        quiet = 1'b1;
        send_item(csa_pkg::CMD_CLEAR, 7'h00);
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (i == SLOT_COUNT / 2)
                quiet = 1'b0;
            send_item(csa_pkg::CMD_ACQUIRE, 7'($urandom));
        end
        send_item(csa_pkg::CMD_ACQUIRE, 7'h00);
        send_item(csa_pkg::CMD_ACQUIRE_CTRL, 7'h00);
        set_slot_limit(8'd255);
        send_item(csa_pkg::CMD_ACQUIRE, 7'h00);
        send_item(csa_pkg::CMD_RELEASE, 7'd64);
        send_item(csa_pkg::CMD_ACQUIRE, 7'h00);
        send_item(csa_pkg::CMD_ACQUIRE, 7'h00);
        send_item(csa_pkg::CMD_RELEASE, 7'h7f);
        send_item(csa_pkg::CMD_ACQUIRE, 7'h00);
        settle();
    endtask

    task automatic test_random_traffic();
        logic [7:0] limits[12];
        int         acquire_pct;
        int         r;
        limits = '{8'd1, 8'd2, 8'd5, 8'd17, 8'd32, 8'd33, 8'd64, 8'd96,
                   8'd127, 8'd128, 8'd255, 8'd0};
        for (int p = 0; p < 14; p++)
        begin
            if (p < 12)
                set_slot_limit(limits[p]);
            else
                set_slot_limit(8'($urandom));
            quiet = (p % 3 == 0);
            acquire_pct = $urandom_range(0, 1) ? 85 : 50;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ((p == 4 && n == PHASE_ITEMS / 2) || $urandom_range(0, 99) == 0)
                    settle();
                r = $urandom_range(0, 99);
                if (r < acquire_pct)
                    send_item(csa_pkg::CMD_ACQUIRE, 7'($urandom));
                else
                begin
                    r = $urandom_range(0, 99);
                    if (r < 60)
                        send_item(csa_pkg::CMD_RELEASE, pick_held_slot());
                    else if (r < 72)
                        send_item(csa_pkg::CMD_RELEASE, 7'($urandom));
                    else if (r < 80)
                        send_item(csa_pkg::CMD_ACQUIRE_CTRL, 7'($urandom));
                    else if (r < 88)
                        send_item(csa_pkg::CMD_RELEASE_CTRL, 7'($urandom));
                    else if (r < 93)
                        send_item(csa_pkg::CMD_CLEAR, 7'($urandom));
                    else
                        send_item(3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)),
                                  7'($urandom));
                end
            end
        end
        settle();
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        cmd = csa_pkg::CMD_ACQUIRE;
        slot = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        held_map = '0;
        ctrl_held = 1'b0;
        cfg_done = 1'b0;
        slot_limit = csa_pkg::SLOTS_RESET;
        quiet = 1'b0;
        repeat (4)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_slot_limits();
        test_map_full();
        test_random_traffic();
        settle();

        $display("%0d items sent: %0d acquires granted, %0d refused", items_sent, grants,
                 refusals);
        $display("slot counts 0 to 255 tried, map filled, control and clear paths hit");
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
